[rtl/dia_pkg.sv]
package dia_pkg;

  // Fixed word geometry
  localparam int unsigned WordWidth    = 32;
  localparam int unsigned ShiftWidth   = 5;
  localparam int unsigned OpWidth      = 6;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned HalfWidth    = 16;
  localparam int unsigned ByteLanes    = WordWidth / ByteWidth;
  localparam int unsigned ByteCntWidth = $clog2(ByteWidth + 1);
  localparam int unsigned CountWidth   = $clog2(WordWidth + 1);
  localparam int unsigned FactorWidth  = ByteWidth + 1;
  localparam int unsigned ProdWidth    = 2 * FactorWidth;

  typedef enum logic [OpWidth-1:0] {
    OpAdd     = 6'd0,
    OpAddc    = 6'd1,
    OpSub     = 6'd2,
    OpSubc    = 6'd3,
    OpAnd     = 6'd4,
    OpNand    = 6'd5,
    OpAndn    = 6'd6,
    OpOr      = 6'd7,
    OpNor     = 6'd8,
    OpOrn     = 6'd9,
    OpXor     = 6'd10,
    OpNxor    = 6'd11,
    OpAsr     = 6'd12,
    OpLsl     = 6'd13,
    OpLslAdd  = 6'd14,
    OpLslSub  = 6'd15,
    OpLsl1    = 6'd16,
    OpLslx    = 6'd17,
    OpLsr     = 6'd18,
    OpLsrAdd  = 6'd19,
    OpLsr1    = 6'd20,
    OpLsrx    = 6'd21,
    OpRol     = 6'd22,
    OpRolAdd  = 6'd23,
    OpRor     = 6'd24,
    OpPopCnt  = 6'd25,
    OpClo     = 6'd26,
    OpCls     = 6'd27,
    OpClz     = 6'd28,
    OpCmpb4   = 6'd29,
    OpExtsb   = 6'd30,
    OpExtsh   = 6'd31,
    OpExtub   = 6'd32,
    OpExtuh   = 6'd33,
    OpMulShSh = 6'd34,
    OpMulShSl = 6'd35,
    OpMulShUh = 6'd36,
    OpMulShUl = 6'd37,
    OpMulSlSh = 6'd38,
    OpMulSlSl = 6'd39,
    OpMulSlUh = 6'd40,
    OpMulSlUl = 6'd41,
    OpMulUhUh = 6'd42,
    OpMulUhUl = 6'd43,
    OpMulUlUh = 6'd44,
    OpMulUlUl = 6'd45,
    OpSext    = 6'd46,
    OpZext    = 6'd47
  } op_e;

  // Shifter outputs for one source word
  typedef struct packed {
    logic [WordWidth-1:0] shl;
    logic [WordWidth-1:0] shr;
    logic [WordWidth-1:0] rol;
    logic [WordWidth-1:0] ror;
    logic [WordWidth-1:0] lo_mask;
    logic [WordWidth-1:0] hi_mask;
  } shift_t;

  // Bit counts of operand a
  typedef struct packed {
    logic [CountWidth-1:0] pop;
    logic [CountWidth-1:0] lead_zeros;
    logic [CountWidth-1:0] lead_ones;
    logic [CountWidth-1:0] lead_sign;
  } count_t;

  typedef struct packed {
    logic [WordWidth-1:0] word;
    logic [WordWidth-1:0] high;
    logic                 carry;
    logic                 overflow;
  } result_t;

endpackage

[rtl/dpu_integer_alu_32_unit.sv]
// Channel  | Direction | Handshake              | Payload
// request  | in        | in_valid_i / in_ready_o | operation_i, operand_a_i, operand_b_i,
//          |           |                         | shift_amount_i, carry_in_i
// result   | out       | out_valid_o / out_ready_i | result_word_o, result_high_o,
//          |           |                         | carry_out_o, overflow_out_o
//
// One request per cycle sustained while out_ready_i drains the result register;
// a request passes the input register, then the result register behind out_valid_o.
// The requests sit in an input register, the ALU is one combinational pass, and the
// result register holds the answer until it is taken.
// A stalled result holds; the input register still drains into it once it frees, so
// in_ready_o is low only while both registers are full and out_ready_i is low.
// Reset (rst_ni low) empties both registers; there is no other state.
module dpu_integer_alu_32_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dia_pkg::OpWidth-1:0]     operation_i,
  input  logic [dia_pkg::WordWidth-1:0]   operand_a_i,
  input  logic [dia_pkg::WordWidth-1:0]   operand_b_i,
  input  logic [dia_pkg::ShiftWidth-1:0]  shift_amount_i,
  input  logic                            carry_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dia_pkg::WordWidth-1:0]   result_word_o,
  output logic [dia_pkg::WordWidth-1:0]   result_high_o,
  output logic                            carry_out_o,
  output logic                            overflow_out_o
);

  logic                            in_valid_q;
  logic [dia_pkg::OpWidth-1:0]     op_q;
  logic [dia_pkg::WordWidth-1:0]   a_q;
  logic [dia_pkg::WordWidth-1:0]   b_q;
  logic [dia_pkg::ShiftWidth-1:0]  amt_q;
  logic                            cin_q;

  logic                            out_valid_q;
  dia_pkg::result_t                res_q;
  dia_pkg::result_t                res_d;

  dia_pkg::op_e                    op;
  dia_pkg::shift_t                 shift;
  dia_pkg::count_t                 count;

  logic                            out_free;
  logic                            in_load;
  logic                            out_load;

  // Advance each register whenever the next one can take its request
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_load    = in_valid_i && in_ready_o;

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      op_q  <= operation_i;
      a_q   <= operand_a_i;
      b_q   <= operand_b_i;
      amt_q <= shift_amount_i;
      cin_q <= carry_in_i;
    end
  end

  assign op = dia_pkg::op_e'(op_q);

  dia_shifter u_shifter (
    .op_i        (op),
    .operand_a_i (a_q),
    .operand_b_i (b_q),
    .amount_i    (amt_q),
    .shift_o     (shift)
  );

  dia_count u_count (
    .operand_a_i (a_q),
    .count_o     (count)
  );

  dia_core u_core (
    .op_i        (op),
    .operand_a_i (a_q),
    .operand_b_i (b_q),
    .carry_in_i  (cin_q),
    .shift_i     (shift),
    .count_i     (count),
    .result_o    (res_d)
  );

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_word_o  = res_q.word;
  assign result_high_o  = res_q.high;
  assign carry_out_o    = res_q.carry;
  assign overflow_out_o = res_q.overflow;

endmodule

[rtl/dia_shifter.sv]
module dia_shifter (
  input  dia_pkg::op_e                    op_i,
  input  logic [dia_pkg::WordWidth-1:0]   operand_a_i,
  input  logic [dia_pkg::WordWidth-1:0]   operand_b_i,
  input  logic [dia_pkg::ShiftWidth-1:0]  amount_i,
  output dia_pkg::shift_t                 shift_o
);

  logic [dia_pkg::WordWidth-1:0]   src;
  logic [dia_pkg::WordWidth-1:0]   ones;
  logic [2*dia_pkg::WordWidth-1:0] dbl_left;
  logic [2*dia_pkg::WordWidth-1:0] dbl_right;

  // Shift-then-add forms shift operand b, everything else shifts operand a
  always_comb begin
    if (op_i inside {dia_pkg::OpLslAdd, dia_pkg::OpLslSub, dia_pkg::OpLsrAdd,
                     dia_pkg::OpRolAdd}) begin
      src = operand_b_i;
    end else begin
      src = operand_a_i;
    end
  end

  assign ones      = '1;
  assign dbl_left  = {src, src} << amount_i;
  assign dbl_right = {src, src} >> amount_i;

  // Rotates come from the doubled word, masks mark the vacated bit positions
  assign shift_o.shl     = src << amount_i;
  assign shift_o.shr     = src >> amount_i;
  assign shift_o.rol     = dbl_left[2*dia_pkg::WordWidth-1:dia_pkg::WordWidth];
  assign shift_o.ror     = dbl_right[dia_pkg::WordWidth-1:0];
  assign shift_o.lo_mask = ~(ones << amount_i);
  assign shift_o.hi_mask = ~(ones >> amount_i);

endmodule

[rtl/dia_count.sv]
module dia_count (
  input  logic [dia_pkg::WordWidth-1:0] operand_a_i,
  output dia_pkg::count_t               count_o
);

  // Leading zeros: per-byte priority encode, then combine the byte counts
  function automatic logic [dia_pkg::CountWidth-1:0] lead_zeros(
    input logic [dia_pkg::WordWidth-1:0] w
  );
    logic [dia_pkg::ByteCntWidth-1:0] lz [dia_pkg::ByteLanes];
    logic [dia_pkg::CountWidth-1:0]   n;
    logic                             done;
    for (int l = 0; l < dia_pkg::ByteLanes; l++) begin
      lz[l] = dia_pkg::ByteCntWidth'(dia_pkg::ByteWidth);
      for (int i = 0; i < dia_pkg::ByteWidth; i++) begin
        if (w[l*dia_pkg::ByteWidth + i]) begin
          lz[l] = dia_pkg::ByteCntWidth'(dia_pkg::ByteWidth - 1 - i);
        end
      end
    end
    n    = '0;
    done = 1'b0;
    for (int l = dia_pkg::ByteLanes - 1; l >= 0; l--) begin
      if (!done) begin
        n    = n + {{(dia_pkg::CountWidth-dia_pkg::ByteCntWidth){1'b0}}, lz[l]};
        done = (lz[l] != dia_pkg::ByteCntWidth'(dia_pkg::ByteWidth));
      end
    end
    return n;
  endfunction

  logic [dia_pkg::ByteCntWidth-1:0] byte_pop [dia_pkg::ByteLanes];
  logic [dia_pkg::CountWidth-1:0]   pop;
  logic [dia_pkg::WordWidth-1:0]    sign_fill;

  // Population count: sum within each byte, then across the bytes
  always_comb begin
    for (int l = 0; l < dia_pkg::ByteLanes; l++) begin
      byte_pop[l] = '0;
      for (int i = 0; i < dia_pkg::ByteWidth; i++) begin
        byte_pop[l] = byte_pop[l] +
                      dia_pkg::ByteCntWidth'(operand_a_i[l*dia_pkg::ByteWidth + i]);
      end
    end
    pop = '0;
    for (int l = 0; l < dia_pkg::ByteLanes; l++) begin
      pop = pop + {{(dia_pkg::CountWidth-dia_pkg::ByteCntWidth){1'b0}}, byte_pop[l]};
    end
  end

  assign sign_fill = {dia_pkg::WordWidth{operand_a_i[dia_pkg::WordWidth-1]}};

  assign count_o.pop        = pop;
  assign count_o.lead_zeros = lead_zeros(operand_a_i);
  assign count_o.lead_ones  = lead_zeros(~operand_a_i);
  assign count_o.lead_sign  = lead_zeros(operand_a_i ^ sign_fill);

endmodule

[rtl/dia_core.sv]
module dia_core (
  input  dia_pkg::op_e                  op_i,
  input  logic [dia_pkg::WordWidth-1:0] operand_a_i,
  input  logic [dia_pkg::WordWidth-1:0] operand_b_i,
  input  logic                          carry_in_i,
  input  dia_pkg::shift_t               shift_i,
  input  dia_pkg::count_t               count_i,
  output dia_pkg::result_t              result_o
);

  localparam int unsigned W  = dia_pkg::WordWidth;
  localparam int unsigned BW = dia_pkg::ByteWidth;
  localparam int unsigned HW = dia_pkg::HalfWidth;

  logic [W-1:0] a;
  logic [W-1:0] b;

  // Adder controls
  logic [W-1:0] add_y;
  logic         add_sub;
  logic         add_cin;
  logic [W:0]   add_sum;
  logic [W-1:0] add_res;
  logic         add_carry;
  logic         add_ovf;

  // Byte multiplier controls
  logic                                   a_hi, a_sgn, b_hi, b_sgn;
  logic [BW-1:0]                          a_byte, b_byte;
  logic signed [dia_pkg::FactorWidth-1:0] fa, fb;
  logic signed [dia_pkg::ProdWidth-1:0]   prod;
  logic [W-1:0]                           mul_word;

  logic [W-1:0] cmp_word;

  assign a = operand_a_i;
  assign b = operand_b_i;

  // Pick the adder operand, direction and carry for the add and sub families
  always_comb begin
    add_y   = b;
    add_sub = 1'b0;
    add_cin = 1'b0;
    case (op_i)
      dia_pkg::OpAddc: begin
        add_cin = carry_in_i;
      end
      dia_pkg::OpSub: begin
        add_sub = 1'b1;
        add_cin = 1'b1;
      end
      dia_pkg::OpSubc: begin
        add_sub = 1'b1;
        add_cin = ~carry_in_i;
      end
      dia_pkg::OpLslAdd: begin
        add_y = shift_i.shl;
      end
      dia_pkg::OpLslSub: begin
        add_y   = shift_i.shl;
        add_sub = 1'b1;
        add_cin = 1'b1;
      end
      dia_pkg::OpLsrAdd: begin
        add_y = shift_i.shr;
      end
      dia_pkg::OpRolAdd: begin
        add_y = shift_i.rol;
      end
      default: begin
        add_y = b;
      end
    endcase
  end

  // Subtract as a plus inverted y; borrow is the inverted carry
  assign add_sum   = {1'b0, a} + {1'b0, (add_sub ? ~add_y : add_y)} +
                     {{W{1'b0}}, add_cin};
  assign add_res   = add_sum[W-1:0];
  assign add_carry = add_sub ? ~add_sum[W] : add_sum[W];
  assign add_ovf   = add_sub ? ((a[W-1] ^ add_y[W-1]) & (a[W-1] ^ add_res[W-1]))
                             : (~(a[W-1] ^ add_y[W-1]) & (a[W-1] ^ add_res[W-1]));

  // Select byte and signedness of each multiply factor
  always_comb begin
    a_hi  = 1'b0;
    a_sgn = 1'b0;
    b_hi  = 1'b0;
    b_sgn = 1'b0;
    case (op_i)
      dia_pkg::OpMulShSh: begin a_hi = 1'b1; a_sgn = 1'b1; b_hi = 1'b1; b_sgn = 1'b1; end
      dia_pkg::OpMulShSl: begin a_hi = 1'b1; a_sgn = 1'b1; b_hi = 1'b0; b_sgn = 1'b1; end
      dia_pkg::OpMulShUh: begin a_hi = 1'b1; a_sgn = 1'b1; b_hi = 1'b1; b_sgn = 1'b0; end
      dia_pkg::OpMulShUl: begin a_hi = 1'b1; a_sgn = 1'b1; b_hi = 1'b0; b_sgn = 1'b0; end
      dia_pkg::OpMulSlSh: begin a_hi = 1'b0; a_sgn = 1'b1; b_hi = 1'b1; b_sgn = 1'b1; end
      dia_pkg::OpMulSlSl: begin a_hi = 1'b0; a_sgn = 1'b1; b_hi = 1'b0; b_sgn = 1'b1; end
      dia_pkg::OpMulSlUh: begin a_hi = 1'b0; a_sgn = 1'b1; b_hi = 1'b1; b_sgn = 1'b0; end
      dia_pkg::OpMulSlUl: begin a_hi = 1'b0; a_sgn = 1'b1; b_hi = 1'b0; b_sgn = 1'b0; end
      dia_pkg::OpMulUhUh: begin a_hi = 1'b1; a_sgn = 1'b0; b_hi = 1'b1; b_sgn = 1'b0; end
      dia_pkg::OpMulUhUl: begin a_hi = 1'b1; a_sgn = 1'b0; b_hi = 1'b0; b_sgn = 1'b0; end
      dia_pkg::OpMulUlUh: begin a_hi = 1'b0; a_sgn = 1'b0; b_hi = 1'b1; b_sgn = 1'b0; end
      dia_pkg::OpMulUlUl: begin a_hi = 1'b0; a_sgn = 1'b0; b_hi = 1'b0; b_sgn = 1'b0; end
      default: begin
        a_hi = 1'b0;
      end
    endcase
  end

  // One shared 9x9 signed multiplier, product sign-extended to the word
  assign a_byte   = a_hi ? a[2*BW-1:BW] : a[BW-1:0];
  assign b_byte   = b_hi ? b[2*BW-1:BW] : b[BW-1:0];
  assign fa       = $signed({a_sgn & a_byte[BW-1], a_byte});
  assign fb       = $signed({b_sgn & b_byte[BW-1], b_byte});
  assign prod     = fa * fb;
  assign mul_word = {{(W-dia_pkg::ProdWidth){prod[dia_pkg::ProdWidth-1]}}, prod};

  // Byte lanes that match read as one
  always_comb begin
    cmp_word = '0;
    for (int l = 0; l < dia_pkg::ByteLanes; l++) begin
      if (a[l*BW +: BW] == b[l*BW +: BW]) begin
        cmp_word[l*BW +: BW] = BW'(1);
      end
    end
  end

  // Final result select; unused opcodes give all zeros
  always_comb begin
    result_o = '0;
    case (op_i)
      dia_pkg::OpAdd, dia_pkg::OpAddc, dia_pkg::OpSub, dia_pkg::OpSubc,
      dia_pkg::OpLslAdd, dia_pkg::OpLslSub, dia_pkg::OpLsrAdd,
      dia_pkg::OpRolAdd: begin
        result_o.word     = add_res;
        result_o.carry    = add_carry;
        result_o.overflow = add_ovf;
      end
      dia_pkg::OpAnd:  result_o.word = a & b;
      dia_pkg::OpNand: result_o.word = ~(a & b);
      dia_pkg::OpAndn: result_o.word = ~a & b;
      dia_pkg::OpOr:   result_o.word = a | b;
      dia_pkg::OpNor:  result_o.word = ~(a | b);
      dia_pkg::OpOrn:  result_o.word = ~a | b;
      dia_pkg::OpXor:  result_o.word = a ^ b;
      dia_pkg::OpNxor: result_o.word = ~(a ^ b);
      dia_pkg::OpAsr:  result_o.word = shift_i.shr | (a[W-1] ? shift_i.hi_mask : '0);
      dia_pkg::OpLsl:  result_o.word = shift_i.shl;
      dia_pkg::OpLsl1: result_o.word = shift_i.shl | shift_i.lo_mask;
      dia_pkg::OpLslx: result_o.word = shift_i.rol & shift_i.lo_mask;
      dia_pkg::OpLsr:  result_o.word = shift_i.shr;
      dia_pkg::OpLsr1: result_o.word = shift_i.shr | shift_i.hi_mask;
      dia_pkg::OpLsrx: result_o.word = shift_i.ror & shift_i.hi_mask;
      dia_pkg::OpRol:  result_o.word = shift_i.rol;
      dia_pkg::OpRor:  result_o.word = shift_i.ror;
      dia_pkg::OpPopCnt:
        result_o.word = {{(W-dia_pkg::CountWidth){1'b0}}, count_i.pop};
      dia_pkg::OpClo:
        result_o.word = {{(W-dia_pkg::CountWidth){1'b0}}, count_i.lead_ones};
      dia_pkg::OpCls:
        result_o.word = {{(W-dia_pkg::CountWidth){1'b0}}, count_i.lead_sign};
      dia_pkg::OpClz:
        result_o.word = {{(W-dia_pkg::CountWidth){1'b0}}, count_i.lead_zeros};
      dia_pkg::OpCmpb4: result_o.word = cmp_word;
      dia_pkg::OpExtsb: result_o.word = {{(W-BW){a[BW-1]}}, a[BW-1:0]};
      dia_pkg::OpExtsh: result_o.word = {{(W-HW){a[HW-1]}}, a[HW-1:0]};
      dia_pkg::OpExtub: result_o.word = {{(W-BW){1'b0}}, a[BW-1:0]};
      dia_pkg::OpExtuh: result_o.word = {{(W-HW){1'b0}}, a[HW-1:0]};
      dia_pkg::OpMulShSh, dia_pkg::OpMulShSl, dia_pkg::OpMulShUh, dia_pkg::OpMulShUl,
      dia_pkg::OpMulSlSh, dia_pkg::OpMulSlSl, dia_pkg::OpMulSlUh, dia_pkg::OpMulSlUl,
      dia_pkg::OpMulUhUh, dia_pkg::OpMulUhUl, dia_pkg::OpMulUlUh,
      dia_pkg::OpMulUlUl: result_o.word = mul_word;
      dia_pkg::OpSext: begin
        result_o.word = a;
        result_o.high = {W{a[W-1]}};
      end
      dia_pkg::OpZext: result_o.word = a;
      default: result_o = '0;
    endcase
  end

endmodule

[rtl/dia_checker.sv]
module dia_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [dia_pkg::WordWidth-1:0]   result_word_o,
  input logic [dia_pkg::WordWidth-1:0]   result_high_o,
  input logic                            carry_out_o,
  input logic                            overflow_out_o
);

  // Hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_word_o) &&
      $stable(result_high_o) && $stable(carry_out_o) && $stable(overflow_out_o))
    else $error("stalled result changed");

  // An empty result register never blocks a new request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request blocked with empty result register");

  // After an accepted request has passed the input register, out_valid_o is high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("accepted request did not advance");

  // The high word is a pure sign fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_high_o == '0 || result_high_o == '1))
    else $error("high word is not a sign fill");

  // A result with a nonzero high word never carries arithmetic flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_high_o != '0) |-> !carry_out_o && !overflow_out_o)
    else $error("flags raised with a high word");

endmodule

bind dpu_integer_alu_32_unit dia_checker u_dia_checker (.*);
